// ----- hw/rtl/ori_pkg.sv -----
// ----------------------------------------------------------------------------
// ori_pkg
// Shared types and fixed constants for the opacity ramp interpolator.
// ----------------------------------------------------------------------------
package ori_pkg;

    // control point store
    localparam int MAX_POINTS = 16;
    localparam int PT_IDX_W   = 4;
    localparam int COORD_W    = 16;

    // pixel and result widths
    localparam int PIX_W      = 8;
    localparam int OPA_W      = 8;
    localparam int CNT_W      = 5;

    // point count limits
    localparam logic [CNT_W-1:0] CNT_MIN = 5'd2;
    localparam logic [CNT_W-1:0] CNT_MAX = 5'd16;

    // saturated opacity
    localparam logic [OPA_W-1:0] OPA_MAX = 8'hFF;

    // stream payload widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    // datapath widths
    localparam int NUM_W  = 18;   // signed pixel offset from the lower point
    localparam int DY_W   = 17;   // signed opacity step
    localparam int PA_W   = 32;   // y0 * width
    localparam int PB_W   = 35;   // step * offset
    localparam int SUM_W  = 36;
    localparam int REM_W  = 42;
    localparam int DIV_W  = 32;   // width shifted by sixteen
    localparam int BIT_W  = 3;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_EVAL  = 1'b1
    } ori_action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH_HI,
        ST_FETCH_LO,
        ST_CALC,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUM,
        ST_SCALE,
        ST_CLAMP,
        ST_DIV,
        ST_DONE
    } ori_state_t;

    // one control point as stored, position in the low half
    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } ori_point_t;

endpackage

// ----- hw/rtl/opacity_ramp_interpolator.sv -----
// ----------------------------------------------------------------------------
// opacity_ramp_interpolator
// Piecewise-linear opacity ramp over up to sixteen stored control points.
// ----------------------------------------------------------------------------
//
//  channel   direction  contents (low bit first)
//  --------  ---------  ----------------------------------------------------
//  s_axis    in         tuser: action; tdata: point_index, point_x,
//                       point_y, pixel_index, zero pad
//  m_axis    out        tdata: result_pixel, opacity
//  cfg       in         cfg_wdata: point_count, written when cfg_we is high
//
//  A write request is stored at once and leaves the block ready. An evaluate
//  request holds the block busy from acceptance until it is ready again, for
//  less time when the result is zero or saturates; the eight-step restoring
//  divider and the single read port of the point memory set that time.
//  Reset clears the control state, the segment pointer and point_count (2);
//  the point memory is not cleared.
//  A stalled result waits in the output register while the next request is
//  taken; a finished result waits in the last state only if that register
//  is still full.
//
module opacity_ramp_interpolator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // point_index[3:0], point_x[19:4], point_y[35:20], pixel_index[43:36]
    input  logic [ori_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // action[0]
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // result_pixel[7:0], opacity[15:8]
    output logic [ori_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [ori_pkg::CNT_W-1:0]       cfg_wdata
);
    import ori_pkg::*;

    // request fields
    ori_action_t            in_action;
    logic [PT_IDX_W-1:0]    in_point_index;
    logic [COORD_W-1:0]     in_point_x;
    logic [COORD_W-1:0]     in_point_y;
    logic [PIX_W-1:0]       in_pixel_index;
    logic                   in_accept;

    // control state
    ori_state_t             state_reg, state_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       cnt;
    logic [PT_IDX_W-1:0]    seg_reg, seg_next;
    logic [PT_IDX_W-1:0]    seg_start;
    logic                   adv_reg, adv_next;
    logic [BIT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic                   out_valid_reg, out_valid_next;

    // payload registers
    logic [PIX_W-1:0]       pix_reg, pix_next;
    ori_point_t             held_reg, held_next;
    ori_point_t             lo_reg, lo_next;
    ori_point_t             hi_reg, hi_next;
    logic [COORD_W-1:0]     d_reg, d_next;
    logic signed [NUM_W-1:0] n_reg, n_next;
    logic signed [DY_W-1:0] dy_reg, dy_next;
    logic [PA_W-1:0]        prod_a_reg, prod_a_next;
    logic signed [PB_W-1:0] prod_b_reg, prod_b_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [REM_W-1:0]       p_reg, p_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [OPA_W-1:0]       q_reg, q_next;
    logic [PIX_W-1:0]       out_pix_reg, out_pix_next;
    logic [OPA_W-1:0]       out_opa_reg, out_opa_next;

    // point memory
    ori_point_t             mem [MAX_POINTS];
    ori_point_t             rd_data_reg;
    logic [PT_IDX_W-1:0]    rd_addr;
    logic                   mem_we;

    // datapath helpers
    logic [DY_W-1:0]        dx_pos, dx_neg;
    logic [NUM_W-1:0]       n_pos, n_neg;
    logic [DIV_W-1:0]       divisor;
    logic [REM_W-1:0]       lim;
    logic [REM_W-1:0]       trial;
    logic [SUM_W-3:0]       s_mag;

    // unpack the request
    assign in_point_index = s_axis_tdata[3:0];
    assign in_point_x     = s_axis_tdata[19:4];
    assign in_point_y     = s_axis_tdata[35:20];
    assign in_pixel_index = s_axis_tdata[43:36];
    assign in_action      = ori_action_t'(s_axis_tuser[0]);
    assign in_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready  = (state_reg == ST_IDLE);

    // points in use, held to the legal range
    always_comb
    begin
        if (count_reg < CNT_MIN)
        begin
            cnt = CNT_MIN;
        end
        else if (count_reg > CNT_MAX)
        begin
            cnt = CNT_MAX;
        end
        else
        begin
            cnt = count_reg;
        end
    end

    // pointer restarts at pixel zero or when it lies past the last segment
    always_comb
    begin
        if ((in_pixel_index == '0) || (({1'b0, seg_reg} + 5'd1) >= cnt))
        begin
            seg_start = '0;
        end
        else
        begin
            seg_start = seg_reg;
        end
    end

    // segment geometry
    assign dx_pos  = {1'b0, hi_reg.x} - {1'b0, lo_reg.x};
    assign dx_neg  = {1'b0, lo_reg.x} - {1'b0, hi_reg.x};
    assign n_pos   = {2'b0, pix_reg, 8'h00} - {2'b0, lo_reg.x};
    assign n_neg   = {2'b0, lo_reg.x} - {2'b0, pix_reg, 8'h00};
    assign divisor = {d_reg, 16'h0000};
    assign lim     = {2'b00, divisor, 8'h00};
    assign trial   = {10'b0, divisor} << bit_cnt_reg;
    assign s_mag   = sum_reg[SUM_W-3:0];

    // next state, memory access and datapath
    always_comb
    begin
        state_next   = state_reg;
        seg_next     = seg_reg;
        adv_next     = adv_reg;
        bit_cnt_next = bit_cnt_reg;
        pix_next     = pix_reg;
        held_next    = held_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        d_next       = d_reg;
        n_next       = n_reg;
        dy_next      = dy_reg;
        prod_a_next  = prod_a_reg;
        prod_b_next  = prod_b_reg;
        sum_next     = sum_reg;
        p_next       = p_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        out_pix_next = out_pix_reg;
        out_opa_next = out_opa_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        rd_addr      = seg_reg;
        mem_we       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_action == ACT_WRITE)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        // read the upper point of the current segment
                        seg_next   = seg_start;
                        pix_next   = in_pixel_index;
                        rd_addr    = seg_start + 4'd1;
                        state_next = ST_FETCH_HI;
                    end
                end
            end

            ST_FETCH_HI:
            begin
                // advance by one segment when the pixel lies past the upper point and a further point is in use
                if (((({1'b0, seg_reg} + 5'd2) < cnt)) &&
                    ({pix_reg, 8'h00} > rd_data_reg.x))
                begin
                    adv_next = 1'b1;
                    seg_next = seg_reg + 4'd1;
                    rd_addr  = seg_reg + 4'd2;
                end
                else
                begin
                    adv_next = 1'b0;
                    rd_addr  = seg_reg;
                end
                held_next  = rd_data_reg;
                state_next = ST_FETCH_LO;
            end

            ST_FETCH_LO:
            begin
                if (adv_reg)
                begin
                    lo_next = held_reg;
                    hi_next = rd_data_reg;
                end
                else
                begin
                    lo_next = rd_data_reg;
                    hi_next = held_reg;
                end
                state_next = ST_CALC;
            end

            ST_CALC:
            begin
                // width and offset with signs normalized; zero width gives t = 0
                if (hi_reg.x == lo_reg.x)
                begin
                    d_next = 16'd1;
                    n_next = '0;
                end
                else if (hi_reg.x < lo_reg.x)
                begin
                    d_next = dx_neg[COORD_W-1:0];
                    n_next = n_neg;
                end
                else
                begin
                    d_next = dx_pos[COORD_W-1:0];
                    n_next = n_pos;
                end
                dy_next    = {1'b0, hi_reg.y} - {1'b0, lo_reg.y};
                state_next = ST_MUL_A;
            end

            ST_MUL_A:
            begin
                prod_a_next = {16'h0000, lo_reg.y} * {16'h0000, d_reg};
                state_next  = ST_MUL_B;
            end

            ST_MUL_B:
            begin
                prod_b_next = PB_W'(dy_reg) * PB_W'(n_reg);
                state_next  = ST_SUM;
            end

            ST_SUM:
            begin
                sum_next   = $signed({4'b0000, prod_a_reg}) +
                             $signed({prod_b_reg[PB_W-1], prod_b_reg});
                state_next = ST_SCALE;
            end

            ST_SCALE:
            begin
                // non-positive numerator gives zero opacity
                if (sum_reg[SUM_W-1] || (sum_reg == '0))
                begin
                    q_next     = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    p_next     = ({8'h00, s_mag} << 8) - {8'h00, s_mag};
                    state_next = ST_CLAMP;
                end
            end

            ST_CLAMP:
            begin
                // quotient of 256 or more saturates
                if (p_reg >= lim)
                begin
                    q_next     = OPA_MAX;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next     = p_reg;
                    q_next       = '0;
                    bit_cnt_next = 3'd7;
                    state_next   = ST_DIV;
                end
            end

            ST_DIV:
            begin
                // one restoring quotient bit per cycle
                if (rem_reg >= trial)
                begin
                    rem_next              = rem_reg - trial;
                    q_next[bit_cnt_reg]   = 1'b1;
                end
                bit_cnt_next = bit_cnt_reg - 3'd1;
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_pix_next   = pix_reg;
                    out_opa_next   = q_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= CNT_MIN;
            seg_reg       <= '0;
            adv_reg       <= 1'b0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_reg       <= seg_next;
            adv_reg       <= adv_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pix_reg     <= pix_next;
        held_reg    <= held_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        d_reg       <= d_next;
        n_reg       <= n_next;
        dy_reg      <= dy_next;
        prod_a_reg  <= prod_a_next;
        prod_b_reg  <= prod_b_next;
        sum_reg     <= sum_next;
        p_reg       <= p_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        out_pix_reg <= out_pix_next;
        out_opa_reg <= out_opa_next;
    end

    // point memory, one write port and one read port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[in_point_index] <= {in_point_y, in_point_x};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // result channel
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_opa_reg, out_pix_reg};

`ifndef SYNTHESIS
    // the chosen segment always ends at a point in use
    a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> (({1'b0, seg_reg} + 5'd1) < cnt))
        else $error("segment pointer beyond last point in use");

    // a positive numerator reaches the clamp check
    a_clamp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLAMP) |-> (p_reg != '0))
        else $error("clamp check with zero numerator");

    // remainder stays below the divisor at the current weight
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |->
        (rem_reg < ({10'b0, divisor} << ({1'b0, bit_cnt_reg} + 4'd1))))
        else $error("divider remainder out of bound");

    // a new result appears only out of the finishing state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside finishing state");
`endif

endmodule
